/* rtl/core/stack_bytecode_execute_unit_defines.svh */
// Assertion helpers shared by the execute unit RTL.
`ifndef STACK_BYTECODE_EXECUTE_UNIT_DEFINES_SVH
`define STACK_BYTECODE_EXECUTE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define SBE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define SBE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/sbe_pkg.sv */
package sbe_pkg;

  // Field widths of the request and result channels
  localparam int ACTION_W = 5;
  localparam int ARG_W    = 16;
  localparam int PC_W     = 16;
  localparam int CVAL_W   = 32;
  localparam int TOP_W    = 32;
  localparam int LEVEL_W  = 7;
  localparam int STATUS_W = 3;

  // Opcodes
  localparam logic [ACTION_W-1:0] OP_POP     = 5'd0;
  localparam logic [ACTION_W-1:0] OP_NOT     = 5'd1;
  localparam logic [ACTION_W-1:0] OP_LDCONST = 5'd2;
  localparam logic [ACTION_W-1:0] OP_LDLOCAL = 5'd3;
  localparam logic [ACTION_W-1:0] OP_STLOCAL = 5'd4;
  localparam logic [ACTION_W-1:0] OP_LDNAME  = 5'd5;
  localparam logic [ACTION_W-1:0] OP_STNAME  = 5'd6;
  localparam logic [ACTION_W-1:0] OP_JFALSE  = 5'd7;
  localparam logic [ACTION_W-1:0] OP_JTRUE   = 5'd8;
  localparam logic [ACTION_W-1:0] OP_JFWD    = 5'd9;
  localparam logic [ACTION_W-1:0] OP_JABS    = 5'd10;
  localparam logic [ACTION_W-1:0] OP_CMP     = 5'd11;
  localparam logic [ACTION_W-1:0] OP_ADD     = 5'd12;
  localparam logic [ACTION_W-1:0] OP_MUL     = 5'd13;
  localparam logic [ACTION_W-1:0] OP_DIV     = 5'd14;
  localparam logic [ACTION_W-1:0] OP_MOD     = 5'd15;
  localparam logic [ACTION_W-1:0] OP_SUB     = 5'd16;
  localparam logic [ACTION_W-1:0] OP_WRCONST = 5'd17;
  localparam logic [ACTION_W-1:0] OP_PEEK    = 5'd18;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UNDER = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OVER  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DIVZ  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BADOP = 3'd4;

  // Compare codes; any other code compares for equality
  localparam logic [ARG_W-1:0] CMP_LT = 16'd0;
  localparam logic [ARG_W-1:0] CMP_LE = 16'd1;
  localparam logic [ARG_W-1:0] CMP_NE = 16'd3;
  localparam logic [ARG_W-1:0] CMP_GT = 16'd4;
  localparam logic [ARG_W-1:0] CMP_GE = 16'd5;

endpackage

/* rtl/core/sbe_in_if.sv */
interface sbe_in_if;
  import sbe_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [ARG_W-1:0]    oparg;
  logic [PC_W-1:0]     pc;
  logic [CVAL_W-1:0]   const_value;

  modport source (output valid, action, oparg, pc, const_value, input ready);
  modport sink   (input valid, action, oparg, pc, const_value, output ready);
endinterface

/* rtl/core/sbe_out_if.sv */
interface sbe_out_if;
  import sbe_pkg::*;

  logic                valid;
  logic                ready;
  logic [PC_W-1:0]     next_pc;
  logic [TOP_W-1:0]    top_value;
  logic [LEVEL_W-1:0]  stack_level;
  logic [STATUS_W-1:0] status;

  modport source (output valid, next_pc, top_value, stack_level, status, input ready);
  modport sink   (input valid, next_pc, top_value, stack_level, status, output ready);
endinterface

/* rtl/core/stack_bytecode_execute_unit.sv */
// Integer stack-machine execute unit.
// cmd channel: one bytecode request per handshake (action, oparg, pc,
// const_value); wrconst loads the constant table instead of executing.
// res channel: one result per request (next_pc, top_value, stack_level,
// status), held in an output register until taken.
// Each request passes IDX_HI and IDX_LO, which reduce oparg to a table
// index, IDX_LO also reading the memories, then EXEC, which executes,
// and DONE, which loads the result register.
// mul, div and mod also iterate in S_ITER between EXEC and DONE, in a
// shared one-bit-per-cycle multiply/divide unit.
// Requests are taken only in IDLE, so one request is in flight at a time:
// the stack left by one instruction feeds the next, and the operand
// stack, locals, names and constants sit in single-port synchronous
// memories. The top of stack is kept in a register so binary operations
// need one stack read.
// Reset empties the stack, then sweeps the local and name tables to zero,
// one entry per cycle over all TABLE_ENTRIES entries, with cmd.ready low.
// When the receiver stalls, the finished result waits in the output
// register; the unit still takes and works on the next request and holds
// its result until the register frees.
`include "stack_bytecode_execute_unit_defines.svh"

module stack_bytecode_execute_unit #(
  parameter int STACK_DEPTH   = 64,
  parameter int TABLE_ENTRIES = 256,
  parameter int WORD_BITS     = 32
) (
  input logic      clk,
  input logic      rst,
  sbe_in_if.sink   cmd,
  sbe_out_if.source res
);
  import sbe_pkg::*;

  localparam int SP_W = $clog2(STACK_DEPTH + 1);
  localparam int AW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int TW   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW   = $clog2(WORD_BITS + 1);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_IDX_HI = 3'd2;
  localparam logic [2:0] S_IDX_LO = 3'd3;
  localparam logic [2:0] S_EXEC   = 3'd4;
  localparam logic [2:0] S_ITER   = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]           state;
  logic [TW-1:0]        clr_idx;
  logic [ACTION_W-1:0]  act_q;
  logic [ARG_W-1:0]     oparg_q;
  logic [PC_W-1:0]      pc_q;
  logic [CVAL_W-1:0]    cval_q;
  logic [ARG_W-1:0]     red;
  logic [TW-1:0]        idx;
  logic [SP_W-1:0]      sp;
  logic [WORD_BITS-1:0] tos;
  logic [PC_W-1:0]      npc_q;
  logic [STATUS_W-1:0]  st_q;

  // Multiply/divide unit
  logic [CW-1:0]        cnt;
  logic [WORD_BITS-1:0] op_x;
  logic [WORD_BITS-1:0] op_y;
  logic [WORD_BITS-1:0] acc;
  logic                 neg_q;
  logic                 neg_r;

  // Memories
  logic [WORD_BITS-1:0] stk_mem [STACK_DEPTH];
  logic [WORD_BITS-1:0] loc_mem [TABLE_ENTRIES];
  logic [WORD_BITS-1:0] nam_mem [TABLE_ENTRIES];
  logic [WORD_BITS-1:0] con_mem [TABLE_ENTRIES];
  logic [WORD_BITS-1:0] stk_rd;
  logic [WORD_BITS-1:0] loc_rd;
  logic [WORD_BITS-1:0] nam_rd;
  logic [WORD_BITS-1:0] con_rd;

  logic                 accept;
  logic [31:0]          red_hi_c;
  logic [31:0]          red_lo_c;
  logic [TW-1:0]        idx_c;
  logic [SP_W-1:0]      sp_m1;
  logic [SP_W-1:0]      sp_m2;

  // Execute-stage decisions
  logic [SP_W-1:0]      sp_next;
  logic [WORD_BITS-1:0] tos_next;
  logic [STATUS_W-1:0]  st_c;
  logic [PC_W-1:0]      npc_c;
  logic                 stk_we;
  logic                 loc_we;
  logic                 nam_we;
  logic                 con_we;
  logic                 go_iter;
  logic [WORD_BITS-1:0] a_val;
  logic [WORD_BITS-1:0] b_val;
  logic [WORD_BITS-1:0] a_mag;
  logic [WORD_BITS-1:0] b_mag;
  logic                 cmp_res;
  logic [WORD_BITS+31:0] cval_ext;

  // Iteration step
  logic [WORD_BITS:0]   trial;
  logic                 ge;
  logic [WORD_BITS-1:0] acc_s;
  logic [WORD_BITS-1:0] y_s;
  logic [WORD_BITS-1:0] x_s;
  logic [WORD_BITS-1:0] iter_res;
  logic                 is_mul;

  logic [WORD_BITS+31:0] tos_ext;
  logic [SP_W+6:0]       sp_ext;

  assign accept    = cmd.valid && cmd.ready;
  assign cmd.ready = (state == S_IDLE);
  assign sp_m1     = sp - SP_W'(1);
  assign sp_m2     = sp - SP_W'(2);
  assign a_val     = stk_rd;
  assign b_val     = tos;
  assign is_mul    = (act_q == OP_MUL);
  assign cval_ext  = {{WORD_BITS{cval_q[CVAL_W-1]}}, cval_q};

  // Reduce oparg modulo TABLE_ENTRIES by conditional subtracts, 8 per cycle
  always_comb begin
    red_hi_c = {16'b0, oparg_q};
    for (int k = 15; k >= 8; k--) begin
      if (red_hi_c >= (32'(TABLE_ENTRIES) << k)) begin
        red_hi_c = red_hi_c - (32'(TABLE_ENTRIES) << k);
      end
    end
  end

  always_comb begin
    red_lo_c = {16'b0, red};
    for (int k = 7; k >= 0; k--) begin
      if (red_lo_c >= (32'(TABLE_ENTRIES) << k)) begin
        red_lo_c = red_lo_c - (32'(TABLE_ENTRIES) << k);
      end
    end
    idx_c = red_lo_c[TW-1:0];
  end

  // Signed compare of second (a) against top (b)
  always_comb begin
    case (oparg_q)
      CMP_LT:  cmp_res = $signed(a_val) < $signed(b_val);
      CMP_LE:  cmp_res = $signed(a_val) <= $signed(b_val);
      CMP_NE:  cmp_res = a_val != b_val;
      CMP_GT:  cmp_res = $signed(a_val) > $signed(b_val);
      CMP_GE:  cmp_res = $signed(a_val) >= $signed(b_val);
      default: cmp_res = a_val == b_val;
    endcase
  end

  assign a_mag = a_val[WORD_BITS-1] ? (~a_val + WORD_BITS'(1)) : a_val;
  assign b_mag = b_val[WORD_BITS-1] ? (~b_val + WORD_BITS'(1)) : b_val;

  // Decode and execute one instruction against tos, second entry and tables
  always_comb begin
    sp_next  = sp;
    tos_next = tos;
    st_c     = ST_OK;
    stk_we   = 1'b0;
    loc_we   = 1'b0;
    nam_we   = 1'b0;
    con_we   = 1'b0;
    go_iter  = 1'b0;
    if (act_q >= OP_LDCONST && act_q <= OP_CMP) begin
      npc_c = pc_q + PC_W'(2);
    end else begin
      npc_c = pc_q + PC_W'(1);
    end
    unique case (act_q) inside
      OP_POP: begin
        if (sp == '0) begin
          st_c = ST_UNDER;
        end else begin
          sp_next  = sp_m1;
          tos_next = stk_rd;
        end
      end
      OP_NOT: begin
        if (sp == '0) begin
          st_c = ST_UNDER;
        end else begin
          tos_next = (tos == '0) ? WORD_BITS'(1) : '0;
        end
      end
      OP_LDCONST, OP_LDLOCAL, OP_LDNAME: begin
        if (sp == SP_W'(STACK_DEPTH)) begin
          st_c = ST_OVER;
        end else begin
          stk_we  = (sp != '0);
          sp_next = sp + SP_W'(1);
          if (act_q == OP_LDCONST) begin
            tos_next = con_rd;
          end else if (act_q == OP_LDLOCAL) begin
            tos_next = loc_rd;
          end else begin
            tos_next = nam_rd;
          end
        end
      end
      OP_STLOCAL, OP_STNAME: begin
        if (sp == '0) begin
          st_c = ST_UNDER;
        end else begin
          loc_we   = (act_q == OP_STLOCAL);
          nam_we   = (act_q == OP_STNAME);
          sp_next  = sp_m1;
          tos_next = stk_rd;
        end
      end
      OP_JFALSE, OP_JTRUE: begin
        if (sp == '0) begin
          st_c = ST_UNDER;
        end else begin
          sp_next  = sp_m1;
          tos_next = stk_rd;
          if ((tos != '0) == (act_q == OP_JTRUE)) begin
            npc_c = oparg_q;
          end
        end
      end
      OP_JFWD: npc_c = pc_q + oparg_q;
      OP_JABS: npc_c = oparg_q;
      OP_CMP, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
        if (sp < SP_W'(2)) begin
          st_c = ST_UNDER;
        end else if ((act_q == OP_DIV || act_q == OP_MOD) && tos == '0) begin
          st_c = ST_DIVZ;
        end else if (act_q == OP_MUL || act_q == OP_DIV || act_q == OP_MOD) begin
          go_iter = 1'b1;
        end else begin
          sp_next = sp_m1;
          if (act_q == OP_CMP) begin
            tos_next = {{(WORD_BITS-1){1'b0}}, cmp_res};
          end else if (act_q == OP_ADD) begin
            tos_next = a_val + b_val;
          end else begin
            tos_next = a_val - b_val;
          end
        end
      end
      OP_WRCONST: begin
        con_we = 1'b1;
        npc_c  = pc_q;
      end
      OP_PEEK: begin
        if (sp == '0) begin
          st_c = ST_UNDER;
        end
      end
      default: st_c = ST_BADOP;
    endcase
  end

  // One step of shift-add multiply or restoring divide
  always_comb begin
    trial = {acc, op_y[WORD_BITS-1]};
    ge    = trial >= {1'b0, op_x};
    if (is_mul) begin
      acc_s = op_y[0] ? (acc + op_x) : acc;
      x_s   = op_x << 1;
      y_s   = op_y >> 1;
    end else begin
      acc_s = ge ? WORD_BITS'(trial - {1'b0, op_x}) : trial[WORD_BITS-1:0];
      x_s   = op_x;
      y_s   = {op_y[WORD_BITS-2:0], ge};
    end
    if (is_mul) begin
      iter_res = acc_s;
    end else if (act_q == OP_DIV) begin
      iter_res = neg_q ? (~y_s + WORD_BITS'(1)) : y_s;
    end else begin
      iter_res = neg_r ? (~acc_s + WORD_BITS'(1)) : acc_s;
    end
  end

  // Sequencer, stack pointer and top-of-stack register
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
      sp      <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + TW'(1);
          if (clr_idx == TW'(TABLE_ENTRIES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= S_IDX_HI;
          end
        end
        S_IDX_HI: state <= S_IDX_LO;
        S_IDX_LO: state <= S_EXEC;
        S_EXEC: begin
          sp    <= sp_next;
          tos   <= tos_next;
          npc_q <= npc_c;
          st_q  <= st_c;
          if (go_iter) begin
            cnt   <= '0;
            acc   <= '0;
            neg_q <= a_val[WORD_BITS-1] ^ b_val[WORD_BITS-1];
            neg_r <= a_val[WORD_BITS-1];
            if (is_mul) begin
              op_x <= a_val;
              op_y <= b_val;
            end else begin
              op_x <= b_mag;
              op_y <= a_mag;
            end
            state <= S_ITER;
          end else begin
            state <= S_DONE;
          end
        end
        S_ITER: begin
          acc  <= acc_s;
          op_x <= x_s;
          op_y <= y_s;
          cnt  <= cnt + CW'(1);
          if (cnt == CW'(WORD_BITS - 1)) begin
            tos   <= iter_res;
            sp    <= sp_m1;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!res.valid || res.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  // Capture the request and the reduced index
  always_ff @(posedge clk) begin
    if (accept) begin
      act_q   <= cmd.action;
      oparg_q <= cmd.oparg;
      pc_q    <= cmd.pc;
      cval_q  <= cmd.const_value;
    end
    if (state == S_IDX_HI) begin
      red <= red_hi_c[ARG_W-1:0];
    end
    if (state == S_IDX_LO) begin
      idx <= idx_c;
    end
  end

  // Operand stack: entries below the top; push spills tos
  always_ff @(posedge clk) begin
    if (state == S_EXEC && stk_we) begin
      stk_mem[sp_m1[AW-1:0]] <= tos;
    end
    if (state == S_IDX_LO) begin
      stk_rd <= stk_mem[sp_m2[AW-1:0]];
    end
  end

  // Locals: cleared after reset, written by stlocal
  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      loc_mem[clr_idx] <= '0;
    end else if (state == S_EXEC && loc_we) begin
      loc_mem[idx] <= tos;
    end
    if (state == S_IDX_LO) begin
      loc_rd <= loc_mem[idx_c];
    end
  end

  // Names: cleared after reset, written by stname
  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      nam_mem[clr_idx] <= '0;
    end else if (state == S_EXEC && nam_we) begin
      nam_mem[idx] <= tos;
    end
    if (state == S_IDX_LO) begin
      nam_rd <= nam_mem[idx_c];
    end
  end

  // Constants: loaded by wrconst only
  always_ff @(posedge clk) begin
    if (state == S_EXEC && con_we) begin
      con_mem[idx] <= cval_ext[WORD_BITS-1:0];
    end
    if (state == S_IDX_LO) begin
      con_rd <= con_mem[idx_c];
    end
  end

  assign tos_ext = {32'b0, tos};
  assign sp_ext  = {7'b0, sp};

  // Output register: load from DONE, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (state == S_DONE && (!res.valid || res.ready)) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!res.valid || res.ready)) begin
      res.next_pc     <= npc_q;
      res.top_value   <= (sp != '0) ? tos_ext[TOP_W-1:0] : '0;
      res.stack_level <= sp_ext[LEVEL_W-1:0];
      res.status      <= st_q;
    end
  end

  `SBE_ASSERT_IMP(a_sp_bound, 1'b1, sp <= SP_W'(STACK_DEPTH), "stack pointer beyond depth")
  `SBE_ASSERT_NXT(a_accept_seq, accept, state == S_IDX_HI, "request not sequenced")
  `SBE_ASSERT_NXT(a_idle_sp_hold, state == S_IDLE, $stable(sp), "stack moved while idle")
  `SBE_ASSERT_NXT(a_res_from_done, !res.valid && state != S_DONE, !res.valid, "stray result")

endmodule
